// File: src/tpi_pkg.sv
// tpi_pkg: shared types and constants for the touch pad injector.
// Holds the action codes, the swipe script table and the result struct.
// No dependencies.
package tpi_pkg;

   // Default pad count and register reset
   localparam int          ZONES_DEFAULT  = 8;
   localparam logic [15:0] TAP_TIME_RESET = 16'd120;

   // Action codes
   localparam logic [2:0] ACT_TAP     = 3'd0;
   localparam logic [2:0] ACT_HOLD    = 3'd1;
   localparam logic [2:0] ACT_RELEASE = 3'd2;
   localparam logic [2:0] ACT_SWIPE   = 3'd3;
   localparam logic [2:0] ACT_TICK    = 3'd4;

   // Swipe script: due time (ms), pad in script order, press or release
   localparam int         SCRIPT_STEPS  = 6;
   localparam logic [7:0] SCRIPT_END_MS = 8'd240;
   localparam logic [7:0] SCRIPT_AT [SCRIPT_STEPS] =
      '{8'd0, 8'd60, 8'd90, 8'd120, 8'd150, 8'd210};
   localparam int         SCRIPT_PAD [SCRIPT_STEPS] = '{0, 1, 0, 2, 1, 2};
   localparam logic       SCRIPT_PRESS [SCRIPT_STEPS] =
      '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

   // One result transaction
   typedef struct packed {
      logic [7:0] active_mask;
      logic       any_active;
      logic       swipe_running;
   } rsp_type;

endpackage

// File: src/touch_pad_injector.sv
// touch_pad_injector: synthetic touch generator for a row of pads.
// Depends on tpi_pkg (action codes, swipe script, result struct).
//
// Usage:
//   req_* channel (valid/ready) carries one event per transaction: tap,
//   set hold, release all, start swipe or time tick. rsp_* channel
//   (valid/ready) returns one result per event: the active pad mask, an
//   any-active bit and a swipe-running bit, all taken after the event.
//   csr_wr_en/csr_wr_data write the tap duration in ms; write it only
//   while no result is outstanding.
// Output: each result is registered in the result or the skid register.
// Throughput: one event per cycle while req_ready is high; pad timers,
//   hold flags and the six script compares all update in one pass between
//   the state registers and the result register.
// Stall: a two-entry output (result register plus skid register) lets one
//   more event in while a result waits; req_ready drops only when both
//   entries are full.
// Reset: synchronous, active high; clears timers, hold flags, the swipe
//   script and the output entries, and loads tap time 120 ms.
module touch_pad_injector #(
   parameter int ZONES = tpi_pkg::ZONES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // event channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_zone,
   input  logic        req_hold_value,
   input  logic        req_direction,
   input  logic [15:0] req_elapsed_ms,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_active_mask,
   output logic        rsp_any_active,
   output logic        rsp_swipe_running,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import tpi_pkg::*;

   // State registers
   logic [15:0]      tap_time_ff;
   logic [15:0]      tap_ff [ZONES];
   logic [ZONES-1:0] held_ff;
   logic [2:0]       step_ff;
   logic             idle_ff;
   logic [7:0]       swipe_time_ff;
   logic             forward_ff;

   logic [15:0]      tap_in [ZONES];
   logic [ZONES-1:0] held_in;
   logic [2:0]       step_in;
   logic             idle_in;
   logic [7:0]       swipe_time_in;
   logic             forward_in;

   // Output entries
   rsp_type out_ff, skid_ff, result_in;
   logic    out_valid_ff, skid_valid_ff;

   logic req_accept;
   logic out_free;
   logic [16:0] time_sum;
   logic [7:0]  time_sat;
   logic [ZONES-1:0] active;

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign out_free   = !out_valid_ff || rsp_ready;

   // Saturated swipe time for a tick
   assign time_sum = {9'd0, swipe_time_ff} + {1'b0, req_elapsed_ms};
   assign time_sat = (time_sum > {9'd0, SCRIPT_END_MS}) ? SCRIPT_END_MS
                                                       : time_sum[7:0];

   // Next state for the event at the input
   always_comb begin
      int pad_idx;
      pad_idx       = 0;
      tap_in        = tap_ff;
      held_in       = held_ff;
      step_in       = step_ff;
      idle_in       = idle_ff;
      swipe_time_in = swipe_time_ff;
      forward_in    = forward_ff;
      case (req_action)
         ACT_TAP: begin
            for (int i = 0; i < ZONES; i++) begin
               if (req_zone == 4'(i)) tap_in[i] = tap_time_ff;
            end
         end
         ACT_HOLD: begin
            for (int i = 0; i < ZONES; i++) begin
               if (req_zone == 4'(i)) held_in[i] = req_hold_value;
            end
         end
         ACT_RELEASE: begin
            for (int i = 0; i < ZONES; i++) tap_in[i] = 16'd0;
            held_in = '0;
            idle_in = 1'b1;
         end
         ACT_SWIPE: begin
            for (int i = 0; i < ZONES; i++) tap_in[i] = 16'd0;
            forward_in    = req_direction;
            step_in       = 3'd0;
            idle_in       = 1'b0;
            swipe_time_in = 8'd0;
         end
         ACT_TICK: begin
            // countdowns saturate at zero
            for (int i = 0; i < ZONES; i++) begin
               tap_in[i] = (tap_ff[i] > req_elapsed_ms) ? tap_ff[i] - req_elapsed_ms
                                                        : 16'd0;
            end
            if (!idle_ff) begin
               swipe_time_in = time_sat;
               // apply due script steps in order; table times ascend
               for (int k = 0; k < SCRIPT_STEPS; k++) begin
                  if (3'(k) >= step_ff && time_sat >= SCRIPT_AT[k]) begin
                     pad_idx = forward_ff ? SCRIPT_PAD[k] : ZONES - 1 - SCRIPT_PAD[k];
                     for (int i = 0; i < ZONES; i++) begin
                        if (i == pad_idx) held_in[i] = SCRIPT_PRESS[k];
                     end
                     step_in = 3'(k + 1);
                  end
               end
               // end of script
               if (time_sat >= SCRIPT_END_MS) begin
                  idle_in = 1'b1;
                  held_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result from the next state
   always_comb begin
      for (int i = 0; i < ZONES; i++) active[i] = held_in[i] || (tap_in[i] != 16'd0);
   end

   for (genvar g = 0; g < 8; g++) begin : g_mask
      if (g < ZONES) begin : g_pad
         assign result_in.active_mask[g] = active[g];
      end else begin : g_none
         assign result_in.active_mask[g] = 1'b0;
      end
   end
   assign result_in.any_active    = |active;
   assign result_in.swipe_running = !idle_in;

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_time_ff   <= TAP_TIME_RESET;
         for (int i = 0; i < ZONES; i++) tap_ff[i] <= 16'd0;
         held_ff       <= '0;
         step_ff       <= 3'd0;
         idle_ff       <= 1'b1;
         swipe_time_ff <= 8'd0;
         forward_ff    <= 1'b1;
      end else begin
         if (csr_wr_en) tap_time_ff <= csr_wr_data;
         if (req_accept) begin
            tap_ff        <= tap_in;
            held_ff       <= held_in;
            step_ff       <= step_in;
            idle_ff       <= idle_in;
            swipe_time_ff <= swipe_time_in;
            forward_ff    <= forward_in;
         end
      end
   end

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else if (req_accept) begin
            out_ff       <= result_in;
            out_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         skid_ff       <= result_in;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_active_mask   = out_ff.active_mask;
   assign rsp_any_active    = out_ff.any_active;
   assign rsp_swipe_running = out_ff.swipe_running;

   // Assertions
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output entry empty");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'(SCRIPT_STEPS))
      else $error("swipe step beyond script");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ACT_RELEASE) |=> (held_ff == '0 && idle_ff))
      else $error("release all left a pad held or a swipe running");

   a_idle_done: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ACT_TICK && !idle_ff && time_sat == SCRIPT_END_MS)
      |=> (idle_ff && step_ff == 3'(SCRIPT_STEPS)))
      else $error("swipe did not finish at script end");

endmodule
